FILE: design/key_value_line_parser_macros.svh
// Assertion macros shared by the key/value line parser.
`ifndef KEY_VALUE_LINE_PARSER_MACROS_SVH
`define KEY_VALUE_LINE_PARSER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define KVLP_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define KVLP_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define KVLP_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/kvlp_pkg.sv
// Shared constants, codes and command/status types of the key/value line parser.
package kvlp_pkg;

  localparam int KEY_LIMIT   = 16;
  localparam int VALUE_LIMIT = 32;

  localparam int KEY_DEPTH = KEY_LIMIT - 1;
  localparam int VAL_DEPTH = VALUE_LIMIT - 1;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int VAL_AW    = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int KEY_CW    = $clog2(KEY_LIMIT);
  localparam int VAL_CW    = $clog2(VALUE_LIMIT + 1);
  localparam int IDX_W     = (KEY_CW > VAL_CW) ? KEY_CW : VAL_CW;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SKIPPED    = 2'd1;
  localparam logic [1:0] ST_FORMAT     = 2'd2;
  localparam logic [1:0] ST_VALUE_LONG = 2'd3;

  typedef struct packed {
    logic       key_wr;
    logic       val_wr;
    logic       emit_key;
    logic       emit_val;
    logic       emit_status;
    logic [1:0] code;
  } kvlp_cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_blank;
    logic is_hash;
    logic is_nl;
    logic is_eq;
    logic key_full;
    logic val_over;
    logic key_last;
    logic val_last;
    logic val_empty;
  } kvlp_stat_t;

endpackage

FILE: design/kvlp_ctrl.sv
// Controller state machine: parse phases and the result emission sequence.
module kvlp_ctrl import kvlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  kvlp_stat_t stat,
  output kvlp_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_SKIP,
    S_KEY,
    S_VALUE,
    S_DISCARD,
    S_EMIT_KEY,
    S_EMIT_VAL,
    S_STATUS
  } state_t;

  state_t     state, state_next;
  logic [1:0] line_status, line_status_next;
  logic       accept;

  assign busy   = (state == S_EMIT_KEY) || (state == S_EMIT_VAL) || (state == S_STATUS);
  assign accept = start && !busy;

  always_comb begin
    state_next       = state;
    line_status_next = line_status;
    cmd              = '0;
    cmd.code         = line_status;
    unique case (state)
      S_SKIP: begin
        if (accept) begin
          if (stat.is_nul) begin
            line_status_next = ST_SKIPPED;
            state_next       = S_STATUS;
          end else if (stat.is_blank) begin
            state_next = S_SKIP;
          end else if (stat.is_hash || stat.is_nl) begin
            line_status_next = ST_SKIPPED;
            state_next       = S_DISCARD;
          end else if (stat.is_eq) begin
            line_status_next = ST_FORMAT;
            state_next       = S_DISCARD;
          end else begin
            cmd.key_wr = 1'b1;
            state_next = S_KEY;
          end
        end
      end
      S_KEY: begin
        if (accept) begin
          if (stat.is_nul) begin
            line_status_next = ST_FORMAT;
            state_next       = S_STATUS;
          end else if (stat.is_eq) begin
            state_next = S_VALUE;
          end else if (stat.is_nl || stat.key_full) begin
            line_status_next = ST_FORMAT;
            state_next       = S_DISCARD;
          end else begin
            cmd.key_wr = 1'b1;
          end
        end
      end
      S_VALUE: begin
        if (accept) begin
          if (stat.is_nul) begin
            if (stat.val_over) begin
              line_status_next = ST_VALUE_LONG;
              state_next       = S_STATUS;
            end else begin
              state_next = S_EMIT_KEY;
            end
          end else begin
            cmd.val_wr = 1'b1;
          end
        end
      end
      S_DISCARD: begin
        if (accept && stat.is_nul) begin
          state_next = S_STATUS;
        end
      end
      S_EMIT_KEY: begin
        cmd.emit_key = 1'b1;
        if (stat.key_last) begin
          state_next = stat.val_empty ? S_STATUS : S_EMIT_VAL;
        end
      end
      S_EMIT_VAL: begin
        cmd.emit_val = 1'b1;
        if (stat.val_last) begin
          state_next = S_STATUS;
        end
      end
      S_STATUS: begin
        cmd.emit_status  = 1'b1;
        line_status_next = ST_OK;
        state_next       = S_SKIP;
      end
      default: begin
        state_next = S_SKIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SKIP;
      line_status <= ST_OK;
    end else begin
      state       <= state_next;
      line_status <= line_status_next;
    end
  end

endmodule

FILE: design/kvlp_dp.sv
// Datapath: byte decode, key and value stores, counters and the result register.
module kvlp_dp import kvlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] line_byte,
  input  kvlp_cmd_t  cmd,
  output kvlp_stat_t stat,
  output logic       strobe,
  output logic [1:0] item_kind,
  output logic [7:0] out_byte,
  output logic [1:0] status_code,
  output logic       last_of_run
);

  logic [7:0]       key_mem [KEY_DEPTH];
  logic [7:0]       val_mem [VAL_DEPTH];
  logic [KEY_CW-1:0] key_count;
  logic [VAL_CW-1:0] value_count;
  logic [VAL_CW-1:0] trimmed_length;
  logic [IDX_W-1:0]  emit_idx;
  logic              val_room;
  logic              is_trim;

  assign val_room = value_count < VAL_CW'(VAL_DEPTH);
  assign is_trim  = stat.is_blank || stat.is_nl;

  always_comb begin
    stat.is_nul    = line_byte == CH_NUL;
    stat.is_blank  = (line_byte == CH_SPACE) || (line_byte == CH_TAB);
    stat.is_hash   = line_byte == CH_HASH;
    stat.is_nl     = line_byte == CH_NL;
    stat.is_eq     = line_byte == CH_EQ;
    stat.key_full  = key_count >= KEY_CW'(KEY_DEPTH);
    stat.val_over  = value_count >= VAL_CW'(VALUE_LIMIT);
    stat.key_last  = IDX_W'(emit_idx + 1'b1) == IDX_W'(key_count);
    stat.val_last  = IDX_W'(emit_idx + 1'b1) == IDX_W'(trimmed_length);
    stat.val_empty = trimmed_length == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count      <= '0;
      value_count    <= '0;
      trimmed_length <= '0;
      emit_idx       <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe <= cmd.emit_key || cmd.emit_val || cmd.emit_status;
      if (cmd.key_wr) begin
        key_count <= KEY_CW'(key_count + 1'b1);
      end
      if (cmd.val_wr) begin
        if (val_room) begin
          value_count <= VAL_CW'(value_count + 1'b1);
          if (!is_trim) begin
            trimmed_length <= VAL_CW'(value_count + 1'b1);
          end
        end else begin
          value_count <= VAL_CW'(VALUE_LIMIT);
        end
      end
      if (cmd.emit_key) begin
        emit_idx <= stat.key_last ? '0 : IDX_W'(emit_idx + 1'b1);
      end
      if (cmd.emit_val) begin
        emit_idx <= stat.val_last ? '0 : IDX_W'(emit_idx + 1'b1);
      end
      if (cmd.emit_status) begin
        key_count      <= '0;
        value_count    <= '0;
        trimmed_length <= '0;
        emit_idx       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[key_count[KEY_AW-1:0]] <= line_byte;
    end
    if (cmd.val_wr && val_room) begin
      val_mem[value_count[VAL_AW-1:0]] <= line_byte;
    end
    if (cmd.emit_key) begin
      item_kind   <= KIND_KEY;
      out_byte    <= key_mem[emit_idx[KEY_AW-1:0]];
      status_code <= ST_OK;
      last_of_run <= 1'b0;
    end else if (cmd.emit_val) begin
      item_kind   <= KIND_VALUE;
      out_byte    <= val_mem[emit_idx[VAL_AW-1:0]];
      status_code <= ST_OK;
      last_of_run <= 1'b0;
    end else if (cmd.emit_status) begin
      item_kind   <= KIND_STATUS;
      out_byte    <= CH_NUL;
      status_code <= cmd.code;
      last_of_run <= 1'b1;
    end
  end

endmodule

FILE: design/key_value_line_parser.sv
// Key/value line parser top level: controller plus datapath.
// Throughput: one line byte per cycle while busy is low; the terminator then
// starts a run of key bytes, value bytes and a status item, one per cycle, or only
// the status item on a skipped line or an error. The first result passes the state
// register and then the result register; busy stays high while the run is emitted.
// Reset (rst, synchronous) returns to skipping leading blanks with no results pending.
`include "key_value_line_parser_macros.svh"

module key_value_line_parser import kvlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] line_byte,
  output logic       strobe,
  output logic [1:0] item_kind,
  output logic [7:0] out_byte,
  output logic [1:0] status_code,
  output logic       last_of_run
);

  kvlp_cmd_t  cmd;
  kvlp_stat_t stat;

  kvlp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  kvlp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .line_byte   (line_byte),
    .cmd         (cmd),
    .stat        (stat),
    .strobe      (strobe),
    .item_kind   (item_kind),
    .out_byte    (out_byte),
    .status_code (status_code),
    .last_of_run (last_of_run)
  );

  `KVLP_NEXT(a_term_starts_run, start && !busy && (line_byte == CH_NUL), busy, "terminator did not start a run")
  `KVLP_IMPLIES(a_idle_only_status, strobe && !busy, last_of_run, "data item shown while idle")
  `KVLP_IMPLIES(a_status_last, strobe && (item_kind == KIND_STATUS), last_of_run, "status item not last")
  `KVLP_IMPLIES(a_data_code, strobe && !last_of_run, status_code == ST_OK, "data item carries a status")

endmodule

FILE: sim/key_value_line_parser_tb.sv
// Self-checking testbench for the key/value line parser: directed and random lines.
`timescale 1ns / 1ps

module key_value_line_parser_tb;
  import kvlp_pkg::*;

  typedef enum logic [1:0] {
    SCAN_LEAD,
    SCAN_KEY,
    SCAN_VALUE,
    SCAN_DROP
  } scan_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
    logic       last;
  } line_item_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] line_byte = CH_NUL;
  logic       busy;
  logic       strobe;
  logic [1:0] item_kind;
  logic [7:0] out_byte;
  logic [1:0] status_code;
  logic       last_of_run;

  scan_t      scan;
  logic [7:0] key_buf [KEY_LIMIT];
  logic [7:0] val_buf [VALUE_LIMIT];
  int         key_len;
  int         val_len;
  int         keep_len;
  logic [1:0] line_code;

  line_item_t pending_items[$];
  int         idle_pct = 0;
  int         sent_bytes = 0;
  int         errors = 0;

  key_value_line_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .line_byte   (line_byte),
    .strobe      (strobe),
    .item_kind   (item_kind),
    .out_byte    (out_byte),
    .status_code (status_code),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void reset_parser();
    scan      = SCAN_LEAD;
    key_len   = 0;
    val_len   = 0;
    keep_len  = 0;
    line_code = ST_OK;
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [7:0] data, logic [1:0] code,
                                     logic last);
    line_item_t it;
    it.kind = kind;
    it.data = data;
    it.code = code;
    it.last = last;
    pending_items.push_back(it);
  endfunction

  function automatic void close_line();
    if (line_code == ST_OK) begin
      for (int i = 0; i < key_len; i++) queue_item(KIND_KEY, key_buf[i], ST_OK, 1'b0);
      for (int i = 0; i < keep_len; i++) queue_item(KIND_VALUE, val_buf[i], ST_OK, 1'b0);
    end
    queue_item(KIND_STATUS, CH_NUL, line_code, 1'b1);
    reset_parser();
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (scan)
      SCAN_LEAD: begin
        if (b == CH_NUL) begin
          line_code = ST_SKIPPED;
          close_line();
        end else if (b == CH_HASH || b == CH_NL) begin
          line_code = ST_SKIPPED;
          scan = SCAN_DROP;
        end else if (b == CH_EQ) begin
          line_code = ST_FORMAT;
          scan = SCAN_DROP;
        end else if (!is_blank(b)) begin
          key_buf[0] = b;
          key_len = 1;
          scan = SCAN_KEY;
        end
      end
      SCAN_KEY: begin
        if (b == CH_NUL) begin
          line_code = ST_FORMAT;
          close_line();
        end else if (b == CH_EQ) begin
          scan = SCAN_VALUE;
        end else if (b == CH_NL || key_len >= KEY_LIMIT - 1) begin
          line_code = ST_FORMAT;
          scan = SCAN_DROP;
        end else begin
          key_buf[key_len] = b;
          key_len++;
        end
      end
      SCAN_VALUE: begin
        if (b == CH_NUL) begin
          if (val_len >= VALUE_LIMIT) line_code = ST_VALUE_LONG;
          close_line();
        end else if (val_len < VALUE_LIMIT - 1) begin
          val_buf[val_len] = b;
          val_len++;
          if (!is_blank(b) && b != CH_NL) keep_len = val_len;
        end else begin
          val_len = VALUE_LIMIT;
        end
      end
      default: begin
        if (b == CH_NUL) close_line();
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    line_item_t want;
    if (rst) begin
      reset_parser();
    end else begin
      if (strobe) begin
        if (pending_items.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d byte %0d code %0d last %0d",
                   $time, item_kind, out_byte, status_code, last_of_run);
          errors++;
        end else begin
          want = pending_items.pop_front();
          check_field("item_kind", int'(want.kind), int'(item_kind));
          check_field("out_byte", int'(want.data), int'(out_byte));
          check_field("status_code", int'(want.code), int'(status_code));
          check_field("last_of_run", int'(want.last), int'(last_of_run));
        end
      end
      if (start && !busy) parse_byte(line_byte);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    start <= 1'b1;
    line_byte <= b;
    do @(posedge clk); while (busy);
    sent_bytes++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 11))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_HASH;
      4: return CH_EQ;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_random_line();
    int         klen;
    int         vlen;
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      klen = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 16) : $urandom_range(1, 6);
      for (int i = 0; i < klen; i++) begin
        do b = noisy_byte();
        while (b == CH_EQ || b == CH_NL || (i == 0 && (is_blank(b) || b == CH_HASH)));
        send_byte(b);
      end
      send_byte(CH_EQ);
      vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 34) : $urandom_range(0, 8);
      repeat (vlen) send_byte(noisy_byte());
    end else begin
      repeat ($urandom_range(0, 10)) send_byte(noisy_byte());
    end
    send_byte(CH_NUL);
  endtask

  task automatic test_skipped_lines();
    idle_pct = 20;
    send_text("");
    send_text(" \t#x=1");
    send_text("\n");
  endtask

  task automatic test_format_errors();
    send_text("=v");
    send_text("k\nx=1");
    send_text("ab");
    send_text("ABCDEFGHIJKLMNOP=x");
  endtask

  task automatic test_values();
    send_text(" \tk=");
    send_text("k= a b \t\n");
    send_text("k= \t\n");
    send_text("a=#=b");
    send_byte(8'h01);
    send_byte(CH_EQ);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_text("ABCDEFGHIJKLMNO=0123456789abcdefghijklmnopqrstu");
    send_text("k=0123456789abcdefghijklmnopqrstuv w");
  endtask

  task automatic test_random_lines(input int pct, input int quota);
    int target;
    idle_pct = pct;
    target = sent_bytes + quota;
    while (sent_bytes < target) send_random_line();
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_skipped_lines();
    test_format_errors();
    test_values();
    test_random_lines(20, 55);
    test_random_lines(48, 54);
    test_random_lines(0, 54);
    start <= 1'b0;
    waited = 0;
    while (pending_items.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_items.size() != 0) begin
      $display("%0t: missing results: expected %0d more, actual 0",
               $time, pending_items.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
